@@ sv/double_ended_queue_assert.svh @@
// Assertion macros for the double-ended queue.
// DEQ_ASSERT_NOW checks a consequent in the same cycle as its antecedent.
// DEQ_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
// Both are sampled on clk and disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DEQ_ASSERT_NOW(lbl, ante, cons, msg)

`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

  // Command codes carried in the cmd field; codes above peek act as peek.
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_PEEK       = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } deq_status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_F,
    OP_PUSH_R,
    OP_POP_F,
    OP_POP_R
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] data;
  } deq_ctrl_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic [31:0] front_value;
    logic [31:0] rear_value;
    logic [4:0]  fill_count;
    logic        empty_flag;
    logic        full_flag;
    logic [1:0]  status;
  } deq_out_t;

endpackage

@@ sv/double_ended_queue.sv @@
// A result beat is offered in the cycle after its command beat is accepted.
// Throughput: one command per cycle; all cells of the chain update on the same clock edge.
// A result waiting under out_stall holds off the next command beat.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// Element storage in the cells is not reset and is never read before it is written.
`timescale 1ns / 1ps

`include "double_ended_queue_assert.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_data
);

  localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  deq_status_t   status_r, status_nxt;
  logic          in_acc;
  logic          q_empty;
  logic          q_full;
  logic          cmd_ok;
  deq_ctrl_t     ctrl;
  logic [SW-1:0] f_q [DEPTH];
  logic [SW-1:0] r_q [DEPTH];
  logic [31:0]   cnt_ext;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == CW'(DEPTH));

  // Decode the command into a cell operation, a status and a new count.
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.data  = in_data.data_in;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    cmd_ok     = 1'b1;
    case (in_data.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (q_full) begin
          status_nxt = ST_PUSH_FULL;
          cmd_ok     = 1'b0;
        end else begin
          ctrl.op   = (in_data.cmd == CMD_PUSH_FRONT) ? OP_PUSH_F : OP_PUSH_R;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (q_empty) begin
          status_nxt = ST_POP_EMPTY;
          cmd_ok     = 1'b0;
        end else begin
          ctrl.op   = (in_data.cmd == CMD_POP_FRONT) ? OP_POP_F : OP_POP_R;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
    if (!in_acc) begin
      ctrl.op   = OP_HOLD;
      count_nxt = count_r;
    end
  end

  // Result beat handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        status_r <= status_nxt;
      end
    end
  end

  // Chain of cells: cell 0 holds the front and rear elements.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] f_prev, f_next, r_prev, r_next;

    if (i == 0) begin : g_first
      assign f_prev = '0;
      assign r_prev = '0;
    end else begin : g_mid
      assign f_prev = f_q[i-1];
      assign r_prev = r_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign f_next = f_q[i];
      assign r_next = r_q[i];
    end else begin : g_body
      assign f_next = f_q[i+1];
      assign r_next = r_q[i+1];
    end

    deq_cell #(
      .SW  (SW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .count  (count_r),
      .f_prev (f_prev),
      .f_next (f_next),
      .r_prev (r_prev),
      .r_next (r_next),
      .f_q    (f_q[i]),
      .r_q    (r_q[i])
    );
  end

  // The result reads the state left by the command; it holds while stalled
  // because no command is taken until the result beat completes.
  assign cnt_ext              = 32'(count_r);
  assign out_valid            = out_valid_r;
  assign out_data.front_value = q_empty ? 32'd0 : 32'(f_q[0]);
  assign out_data.rear_value  = q_empty ? 32'd0 : 32'(r_q[0]);
  assign out_data.fill_count  = cnt_ext[4:0];
  assign out_data.empty_flag  = q_empty;
  assign out_data.full_flag   = q_full;
  assign out_data.status      = status_r;

  `DEQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(DEPTH), "count above capacity")
  `DEQ_ASSERT_NEXT(a_pop_empty, in_acc && q_empty && (in_data.cmd == CMD_POP_FRONT || in_data.cmd == CMD_POP_REAR), out_valid_r && status_r == ST_POP_EMPTY, "pop on empty not refused")
  `DEQ_ASSERT_NEXT(a_refused_hold, in_acc && !cmd_ok, $stable(count_r), "refused command changed count")
  `DEQ_ASSERT_NEXT(a_push_count, in_acc && cmd_ok && (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_PUSH_REAR), count_r == $past(count_r) + CW'(1), "push did not grow count")
  `DEQ_ASSERT_NOW(a_single_elem, out_valid_r && count_r == CW'(1), out_data.front_value == out_data.rear_value, "front and rear chains disagree")

endmodule

@@ sv/deq_cell.sv @@
`timescale 1ns / 1ps

// One position of the queue. The cell holds two elements: the one at its
// distance from the front and the one at its distance from the rear. Pushes
// and pops at an end shift the matching chain by one position, while a push
// at the far end writes the cell whose index equals the current count.
module deq_cell
  import deq_pkg::*;
#(
  parameter int SW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  deq_ctrl_t     ctrl,
  input  logic [CW-1:0] count,
  input  logic [SW-1:0] f_prev,
  input  logic [SW-1:0] f_next,
  input  logic [SW-1:0] r_prev,
  input  logic [SW-1:0] r_next,
  output logic [SW-1:0] f_q,
  output logic [SW-1:0] r_q
);

  logic [SW-1:0] f_r, f_nxt;
  logic [SW-1:0] r_r, r_nxt;
  logic [SW-1:0] din;
  logic          at_end;
  logic          at_head;

  assign din     = ctrl.data[SW-1:0];
  assign at_end  = (count == CW'(IDX));
  assign at_head = (IDX == 0);

  // Next value of both chain elements for the broadcast operation.
  always_comb begin
    f_nxt = f_r;
    r_nxt = r_r;
    case (ctrl.op)
      OP_PUSH_F: begin
        f_nxt = at_head ? din : f_prev;
        if (at_end) begin
          r_nxt = din;
        end
      end
      OP_PUSH_R: begin
        r_nxt = at_head ? din : r_prev;
        if (at_end) begin
          f_nxt = din;
        end
      end
      OP_POP_F: begin
        f_nxt = f_next;
      end
      OP_POP_R: begin
        r_nxt = r_next;
      end
      default: begin
        f_nxt = f_r;
        r_nxt = r_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    r_r <= r_nxt;
  end

  assign f_q = f_r;
  assign r_q = r_r;

endmodule

@@ dv/double_ended_queue_test.sv @@
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 450;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  // Shadow copy of the queue contents and pointers. The 4-bit pointers
  // wrap at the queue depth of 16 on their own.
  logic [31:0] shadow_slots [QUEUE_DEPTH];
  logic [3:0]  shadow_head = '0;
  logic [3:0]  shadow_tail = '0;
  logic [4:0]  shadow_held = '0;

  deq_out_t expected_results [$];

  int cycle_count = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int pops_refused = 0;
  int pushes_refused = 0;
  int full_results = 0;
  bit quiet_mode = 1'b0;
  int stall_left = 0;

  double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one command to the shadow queue and returns the result it should give.
  function automatic deq_out_t deque_apply(deq_in_t beat);
    deq_out_t res;
    res = '0;
    res.status = ST_DONE;
    case (beat.cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_held == 5'(QUEUE_DEPTH)) begin
          res.status = ST_PUSH_FULL;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = beat.data_in;
          shadow_held = shadow_held + 5'd1;
        end
      end
      CMD_PUSH_REAR: begin
        if (shadow_held == 5'(QUEUE_DEPTH)) begin
          res.status = ST_PUSH_FULL;
        end else begin
          shadow_slots[shadow_tail] = beat.data_in;
          shadow_tail = shadow_tail + 4'd1;
          shadow_held = shadow_held + 5'd1;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_held == 5'd0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          shadow_head = shadow_head + 4'd1;
          shadow_held = shadow_held - 5'd1;
        end
      end
      CMD_POP_REAR: begin
        if (shadow_held == 5'd0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          shadow_tail = shadow_tail - 4'd1;
          shadow_held = shadow_held - 5'd1;
        end
      end
      default: begin
        // Peek and the unused codes leave the queue alone.
      end
    endcase
    if (shadow_held != 5'd0) begin
      res.front_value = shadow_slots[shadow_head];
      res.rear_value  = shadow_slots[shadow_tail - 4'd1];
    end
    res.fill_count = shadow_held;
    res.empty_flag = (shadow_held == 5'd0);
    res.full_flag  = (shadow_held == 5'(QUEUE_DEPTH));
    if (res.status == ST_POP_EMPTY) pops_refused++;
    if (res.status == ST_PUSH_FULL) pushes_refused++;
    if (res.full_flag) full_results++;
    return res;
  endfunction

  // Predict on every accepted command beat and check every accepted result beat.
  always @(posedge clk) begin
    deq_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(deque_apply(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat with nothing expected: front=%h rear=%h count=%0d",
                     out_data.front_value, out_data.rear_value, out_data.fill_count);
          end
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          results_checked++;
          if (out_data.front_value !== want.front_value ||
              out_data.rear_value !== want.rear_value ||
              out_data.fill_count !== want.fill_count ||
              out_data.empty_flag !== want.empty_flag ||
              out_data.full_flag !== want.full_flag ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d expected front=%h rear=%h count=%0d empty=%b full=%b st=%0d",
                       results_checked, want.front_value, want.rear_value,
                       want.fill_count, want.empty_flag, want.full_flag, want.status);
              $display("result %0d got      front=%h rear=%h count=%0d empty=%b full=%b st=%0d",
                       results_checked, out_data.front_value, out_data.rear_value,
                       out_data.fill_count, out_data.empty_flag, out_data.full_flag,
                       out_data.status);
            end
          end
        end
      end
    end
  end

  // Receiver back-pressure: random stall stretches, none in quiet mode.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one command beat after a random gap and waits until it is taken.
  task automatic send_cmd(input logic [2:0] code, input logic [31:0] value);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: code, data_in: value};
    do @(posedge clk); while (in_stall);
    commands_sent++;
  endtask

  // Refusals on an empty queue, peeks, and the data extremes.
  task automatic test_empty_edges();
    send_cmd(CMD_POP_FRONT, 32'h1234_5678);
    send_cmd(CMD_POP_REAR, 32'hFFFF_FFFF);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(3'd7, 32'hA5A5_A5A5);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_PUSH_REAR, 32'hFFFF_FFFF);
    send_cmd(CMD_POP_REAR, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
  endtask

  // Fills the queue from both ends so the head wraps down, then pushes on full.
  task automatic test_fill_and_overflow();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_cmd((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom());
    end
    send_cmd(CMD_PUSH_FRONT, 32'hDEAD_0001);
    send_cmd(CMD_PUSH_REAR, 32'hDEAD_0002);
  endtask

  // Random traffic in phases that lean toward filling, draining or neither,
  // so the queue crosses empty and full many times with wrapped pointers.
  task automatic test_random_traffic();
    int sent;
    int phase_left;
    int push_pct;
    int roll;
    logic [2:0] code;
    logic [31:0] value;
    sent = 0;
    phase_left = 0;
    push_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 50);
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
        quiet_mode = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        code = (roll < 5) ? CMD_PEEK : 3'($urandom_range(5, 7));
      end else if ($urandom_range(0, 99) < push_pct) begin
        code = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else begin
        code = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
      end
      case ($urandom_range(0, 19))
        0: value = 32'h0000_0000;
        1: value = 32'hFFFF_FFFF;
        default: value = $urandom();
      endcase
      send_cmd(code, value);
      sent++;
      phase_left--;
    end
    quiet_mode = 1'b0;
  endtask

  // Drop valid, drain the outstanding results and let the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < QUEUE_DEPTH; i++) shadow_slots[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_edges();
    test_fill_and_overflow();
    test_random_traffic();
    drain_results();

    $display("%0d commands sent, %0d results checked in %0d cycles.",
             commands_sent, results_checked, cycle_count);
    $display("%0d pops refused on empty, %0d pushes refused on full, %0d full results.",
             pops_refused, pushes_refused, full_results);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
